// ----- rtl/c16_pkg.sv -----
// Package with shared types and constants of the 16-bit core.
`timescale 1ns / 1ps
package c16_pkg;

   localparam int unsigned WORD_W = 16;

   typedef enum logic [1:0] {
      OP_LOAD = 2'd0,
      OP_EXEC = 2'd1,
      OP_IN   = 2'd2,
      OP_OUT  = 2'd3
   } op_type;

   // Special register indexes.
   localparam logic [2:0] S_PC = 3'd0;
   localparam logic [2:0] S_HI = 3'd2;
   localparam logic [2:0] S_LOW = 3'd3;
   localparam logic [2:0] S_CLK = 3'd4;
   localparam logic [2:0] S_STAT = 3'd5;
   localparam logic [2:0] S_IN = 3'd6;
   localparam logic [2:0] S_OUT = 3'd7;

   // Status bit positions.
   localparam int unsigned B_CARRY = 0;
   localparam int unsigned B_FAULT = 1;
   localparam int unsigned B_INW = 2;
   localparam int unsigned B_OUTW = 3;
   localparam int unsigned B_OTYPE = 4;
   localparam int unsigned B_KILL = 5;
   localparam int unsigned B_CMP = 6;
   localparam int unsigned B_DEBUG = 7;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FETCH0,
      ST_FETCH1,
      ST_FETCH2,
      ST_DECODE,
      ST_MEM0,
      ST_MEM1,
      ST_MEM2,
      ST_STORE1,
      ST_ITER,
      ST_FINISH,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic [1:0]  op;
      logic [16:0] mem_addr;
      logic [7:0]  mem_byte;
      logic [15:0] in_word;
   } req_type;

   typedef struct packed {
      logic        accepted;
      logic [15:0] out_word;
      logic        out_kind;
      logic        halted;
      logic        debug_hit;
      logic        arith_fault;
      logic [15:0] pc_now;
   } rsp_type;

   // Command to the iterative multiply and divide unit.
   typedef struct packed {
      logic        start;
      logic        is_div;
      logic        is_signed;
      logic [15:0] a;
      logic [15:0] b;
   } md_cmd_type;

   typedef struct packed {
      logic        done;
      logic [15:0] hi;
      logic [15:0] lo;
   } md_res_type;

endpackage

// ----- rtl/c16_if.sv -----
// Valid/ready channel interfaces for requests and responses.
`timescale 1ns / 1ps
interface c16_req_if;
   logic valid;
   logic ready;
   c16_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface c16_rsp_if;
   logic valid;
   logic ready;
   c16_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/c16_ram.sv -----
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module c16_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 131072
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end
endmodule

// ----- rtl/c16_muldiv.sv -----
// Iterative shift-add multiplier and restoring divider, one bit per cycle.
`timescale 1ns / 1ps
module c16_muldiv (
   input  logic                clock,
   input  logic                reset,
   input  c16_pkg::md_cmd_type cmd,
   output c16_pkg::md_res_type res
);
   logic        busy_ff, busy_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        div_ff, div_in;
   logic        negq_ff, negq_in;
   logic        negr_ff, negr_in;
   logic [31:0] acc_ff, acc_in;
   logic [15:0] opb_ff, opb_in;
   logic [15:0] quo_ff, quo_in;
   logic        done_ff, done_in;

   logic [15:0] mag_a, mag_b;
   logic [16:0] trial;
   logic [15:0] q_fix, r_fix;
   logic [31:0] p_fix;

   always_comb begin
      mag_a = (cmd.is_signed && cmd.a[15]) ? 16'(-cmd.a) : cmd.a;
      mag_b = (cmd.is_signed && cmd.b[15]) ? 16'(-cmd.b) : cmd.b;
      busy_in = busy_ff;
      cnt_in = cnt_ff;
      div_in = div_ff;
      negq_in = negq_ff;
      negr_in = negr_ff;
      acc_in = acc_ff;
      opb_in = opb_ff;
      quo_in = quo_ff;
      done_in = 1'b0;
      trial = {acc_ff[31:16], quo_ff[15]} - {1'b0, opb_ff};
      if (cmd.start) begin
         busy_in = 1'b1;
         cnt_in = 5'd16;
         div_in = cmd.is_div;
         negq_in = cmd.is_signed && (cmd.a[15] ^ cmd.b[15]);
         negr_in = cmd.is_signed && cmd.a[15];
         acc_in = 32'd0;
         opb_in = mag_b;
         quo_in = mag_a;
      end else if (busy_ff) begin
         if (div_ff) begin
            // Remainder sits in acc[31:16]; dividend shifts out of quo.
            if (!trial[16]) begin
               acc_in[31:16] = trial[15:0];
               quo_in = {quo_ff[14:0], 1'b1};
            end else begin
               acc_in[31:16] = {acc_ff[30:16], quo_ff[15]};
               quo_in = {quo_ff[14:0], 1'b0};
            end
         end else begin
            acc_in = {acc_ff[30:0], 1'b0} + (quo_ff[15] ? {16'd0, opb_ff} : 32'd0);
            quo_in = {quo_ff[14:0], 1'b0};
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= 5'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      div_ff <= div_in;
      negq_ff <= negq_in;
      negr_ff <= negr_in;
      acc_ff <= acc_in;
      opb_ff <= opb_in;
      quo_ff <= quo_in;
   end

   always_comb begin
      q_fix = negq_ff ? 16'(-quo_ff) : quo_ff;
      r_fix = negr_ff ? 16'(-acc_ff[31:16]) : acc_ff[31:16];
      p_fix = negq_ff ? 32'(-acc_ff) : acc_ff;
      res.done = done_ff;
      res.hi = div_ff ? q_fix : p_fix[31:16];
      res.lo = div_ff ? r_fix : p_fix[15:0];
   end
endmodule

// ----- rtl/custom_16bit_cpu_core.sv -----
// Top level of the 16-bit core: sequencer, register files and memory.
`timescale 1ns / 1ps
// This core takes one request beat at a time and returns exactly one response
// beat for it. A memory load, an offer or take of a word, and an execute beat
// after the core has halted each go from the accepting idle state straight to
// the finishing state. An executed instruction reads its two opcode bytes
// through the single memory port in states FETCH0 to FETCH2 and then decodes.
// It then passes MEM0 and MEM2 on a byte load, MEM0 and STORE1 on a word
// store, MEM0, MEM1 and MEM2 on a word load, and waits in ITER on multiply or
// divide, which run one bit a cycle in the shared iterative unit. A byte store
// is written during decode. The single-port byte memory, with its registered
// read, sets the length of every memory access. The core is not ready while a
// beat is being processed, and the response register must be drained before
// the next request is taken.
// Memory content is undefined until written and has no clearing pass.
module custom_16bit_cpu_core #(
   parameter int unsigned MEM_BYTES = 131072
) (
   input  logic       clock,
   input  logic       reset,
   c16_req_if.sink    req,
   c16_rsp_if.source  rsp
);
   localparam int unsigned AW = $clog2(MEM_BYTES);

   c16_pkg::state_type state_ff, state_in;
   c16_pkg::req_type   cur_ff;
   logic [15:0] gpr_ff [16];
   logic [15:0] spr_ff [8];
   logic [15:0] ins_ff, ins_in;
   logic [7:0]  lob_ff, lob_in;
   c16_pkg::rsp_type rsp_ff, rsp_in;
   logic        rsp_valid_ff;

   logic [AW-1:0] mem_addr;
   logic          mem_we;
   logic [7:0]    mem_wdata, mem_rdata;

   c16_pkg::md_cmd_type md_cmd;
   c16_pkg::md_res_type md_res;

   c16_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
      .clock (clock),
      .we    (mem_we),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   c16_muldiv u_md (
      .clock (clock),
      .reset (reset),
      .cmd   (md_cmd),
      .res   (md_res)
   );

   // Instruction fields.
   logic [3:0]  top, mid, lo4, hi4;
   logic [15:0] ra1, rb1, rc1, ra2, rb2, ra3;
   logic [15:0] stat;
   logic [7:0]  lo8;
   logic [16:0] word_addr;
   logic [15:0] pc;

   always_comb begin
      top = ins_ff[15:12];
      mid = ins_ff[11:8];
      hi4 = ins_ff[7:4];
      lo4 = ins_ff[3:0];
      lo8 = ins_ff[7:0];
      ra1 = gpr_ff[mid];
      rb1 = gpr_ff[hi4];
      rc1 = gpr_ff[lo4];
      ra2 = gpr_ff[hi4];
      rb2 = gpr_ff[lo4];
      ra3 = gpr_ff[lo4];
      stat = spr_ff[c16_pkg::S_STAT];
      pc = spr_ff[c16_pkg::S_PC];
      word_addr = {rb2, 1'b0};
   end

   // Which second-level memory operation, or a multiply or divide, applies.
   logic is_second, is_ldw, is_stw, is_ldb, is_stb, is_md;
   always_comb begin
      is_second = (top == 4'd0);
      is_ldw = is_second && (mid == 4'd4);
      is_stw = is_second && (mid == 4'd5);
      is_ldb = is_second && (mid == 4'd6 || mid == 4'd7);
      is_stb = is_second && (mid == 4'd12);
      is_md = (top == 4'd2 || top == 4'd3 ||
               ((top == 4'd4 || top == 4'd5) && rc1 != 16'd0));
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         c16_pkg::ST_IDLE: begin
            if (req.valid && !rsp_valid_ff) begin
               if (req.data.op == c16_pkg::OP_EXEC && !stat[c16_pkg::B_KILL]) begin
                  state_in = c16_pkg::ST_FETCH0;
               end else begin
                  state_in = c16_pkg::ST_FINISH;
               end
            end
         end
         c16_pkg::ST_FETCH0: state_in = c16_pkg::ST_FETCH1;
         c16_pkg::ST_FETCH1: state_in = c16_pkg::ST_FETCH2;
         c16_pkg::ST_FETCH2: state_in = c16_pkg::ST_DECODE;
         c16_pkg::ST_DECODE: begin
            if (is_ldw || is_ldb || is_stw) begin
               state_in = c16_pkg::ST_MEM0;
            end else if (is_md) begin
               state_in = c16_pkg::ST_ITER;
            end else begin
               state_in = c16_pkg::ST_FINISH;
            end
         end
         c16_pkg::ST_MEM0: begin
            if (is_stw) begin
               state_in = c16_pkg::ST_STORE1;
            end else if (is_ldb) begin
               state_in = c16_pkg::ST_MEM2;
            end else begin
               state_in = c16_pkg::ST_MEM1;
            end
         end
         c16_pkg::ST_MEM1: state_in = c16_pkg::ST_MEM2;
         c16_pkg::ST_MEM2: state_in = c16_pkg::ST_FINISH;
         c16_pkg::ST_STORE1: state_in = c16_pkg::ST_FINISH;
         c16_pkg::ST_ITER: if (md_res.done) state_in = c16_pkg::ST_FINISH;
         c16_pkg::ST_FINISH: state_in = c16_pkg::ST_IDLE;
         default: state_in = c16_pkg::ST_IDLE;
      endcase
   end

   // Memory port drive, fetch registers and multiply/divide command.
   always_comb begin
      mem_we = 1'b0;
      mem_wdata = 8'd0;
      mem_addr = AW'(pc);
      ins_in = ins_ff;
      lob_in = lob_ff;
      md_cmd.start = 1'b0;
      md_cmd.is_div = top[2];
      md_cmd.is_signed = (top == 4'd2 || top == 4'd4);
      md_cmd.a = rb1;
      md_cmd.b = rc1;
      case (state_ff)
         c16_pkg::ST_FETCH0: mem_addr = AW'(pc);
         c16_pkg::ST_FETCH1: begin
            mem_addr = AW'({1'b0, pc} + 17'd1);
            ins_in[7:0] = mem_rdata;
         end
         c16_pkg::ST_FETCH2: ins_in[15:8] = mem_rdata;
         c16_pkg::ST_DECODE: begin
            md_cmd.start = is_md;
            if (is_stb) begin
               mem_we = 1'b1;
               mem_addr = AW'(rb2);
               mem_wdata = ra2[7:0];
            end
         end
         c16_pkg::ST_MEM0: begin
            if (is_ldb) begin
               mem_addr = AW'(rb2);
            end else begin
               mem_addr = AW'(word_addr);
            end
            if (is_stw) begin
               mem_we = 1'b1;
               mem_wdata = ra2[7:0];
            end
         end
         c16_pkg::ST_MEM1: begin
            mem_addr = AW'(word_addr + 17'd1);
            lob_in = mem_rdata;
         end
         c16_pkg::ST_MEM2: begin
            // Hold the load address so the read data is still there at finish.
            if (is_ldb) begin
               mem_addr = AW'(rb2);
            end else begin
               mem_addr = AW'(word_addr + 17'd1);
            end
         end
         c16_pkg::ST_STORE1: begin
            mem_we = 1'b1;
            mem_addr = AW'(word_addr + 17'd1);
            mem_wdata = ra2[15:8];
         end
         c16_pkg::ST_FINISH: begin
            if (cur_ff.op == c16_pkg::OP_LOAD) begin
               mem_we = 1'b1;
               mem_addr = AW'(cur_ff.mem_addr);
               mem_wdata = cur_ff.mem_byte;
            end
         end
         default: ;
      endcase
   end

   // Architectural update at the end of an instruction or a host beat.
   logic [15:0] g_n [16];
   logic [15:0] s_n [8];
   logic [16:0] sum;
   logic [15:0] nxt;
   logic [15:0] c12;
   logic [4:0]  shamt_ok;

   always_comb begin
      for (int i = 0; i < 16; i++) g_n[i] = gpr_ff[i];
      for (int i = 0; i < 8; i++) s_n[i] = spr_ff[i];
      nxt = 16'(pc + 16'd2);
      sum = 17'd0;
      c12 = {{4{ins_ff[11]}}, ins_ff[11:0]};
      shamt_ok = 5'd0;
      rsp_in = '0;
      if (cur_ff.op == c16_pkg::OP_EXEC && !stat[c16_pkg::B_KILL]) begin
         case (top)
            4'd0: begin
               case (mid)
                  4'd0: begin
                     case (hi4)
                        4'd1: if (stat[c16_pkg::B_CMP]) nxt = {ra3[15:1], 1'b0};
                        4'd2, 4'd11: begin
                           s_n[c16_pkg::S_OUT] = ra3;
                           s_n[c16_pkg::S_STAT][c16_pkg::B_OTYPE] = 1'b0;
                           s_n[c16_pkg::S_STAT][c16_pkg::B_OUTW] = 1'b1;
                        end
                        4'd4: s_n[c16_pkg::S_STAT][c16_pkg::B_KILL] = 1'b1;
                        4'd5: g_n[lo4] = 16'(-ra3);
                        4'd6: g_n[lo4] = ~ra3;
                        4'd7: s_n[c16_pkg::S_STAT][c16_pkg::B_CMP] = (ra3 == 16'd0);
                        4'd8: s_n[c16_pkg::S_STAT][c16_pkg::B_CMP] = (ra3 != 16'd0);
                        4'd9: begin
                           s_n[c16_pkg::S_OUT] = spr_ff[lo4[2:0]];
                           s_n[c16_pkg::S_STAT][c16_pkg::B_OTYPE] = 1'b0;
                           s_n[c16_pkg::S_STAT][c16_pkg::B_OUTW] = 1'b1;
                        end
                        4'd10: nxt = {ra3[15:1], 1'b0};
                        4'd12: s_n[c16_pkg::S_STAT][c16_pkg::B_DEBUG] = 1'b1;
                        default: ;
                     endcase
                  end
                  4'd1: g_n[hi4] = spr_ff[lo4[2:0]];
                  4'd2: g_n[hi4] = rb2;
                  4'd3: g_n[hi4] = stat & (16'd1 << lo4);
                  4'd4: g_n[hi4] = {mem_rdata, lob_ff};
                  4'd6: g_n[hi4] = {{8{mem_rdata[7]}}, mem_rdata};
                  4'd7: g_n[hi4] = {8'd0, mem_rdata};
                  4'd8: s_n[c16_pkg::S_STAT][c16_pkg::B_CMP] =
                           ($signed(ra2) > $signed(rb2));
                  4'd9: begin
                     g_n[9] = {15'd0, $signed(ra2) >= $signed(rb2)};
                     // The compare sees the updated register 9.
                     s_n[c16_pkg::S_STAT][c16_pkg::B_CMP] =
                        ($signed(hi4 == 4'd9 ? g_n[9] : ra2) >=
                         $signed(lo4 == 4'd9 ? g_n[9] : rb2));
                  end
                  4'd10: s_n[c16_pkg::S_STAT][c16_pkg::B_CMP] =
                            ($signed(ra2) < $signed(rb2));
                  4'd11: s_n[c16_pkg::S_STAT][c16_pkg::B_CMP] =
                            ($signed(ra2) <= $signed(rb2));
                  4'd13, 4'd14, 4'd15: begin
                     if (rb2 < 16'd16) begin
                        shamt_ok = {1'b0, rb2[3:0]};
                        case (mid)
                           4'd13: g_n[hi4] = ra2 << shamt_ok;
                           4'd14: g_n[hi4] = ra2 >> shamt_ok;
                           default: g_n[hi4] = 16'($signed(ra2) >>> shamt_ok);
                        endcase
                     end else begin
                        s_n[c16_pkg::S_STAT][c16_pkg::B_FAULT] = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
            4'd1: begin
               sum = {rb1[15], rb1} + {rc1[15], rc1};
               s_n[c16_pkg::S_STAT][c16_pkg::B_CARRY] = sum[16];
               g_n[mid] = sum[15:0];
            end
            4'd2, 4'd3: begin
               s_n[c16_pkg::S_HI] = md_res.hi;
               s_n[c16_pkg::S_LOW] = md_res.lo;
               g_n[mid] = md_res.lo;
            end
            4'd4, 4'd5: begin
               if (rc1 == 16'd0) begin
                  s_n[c16_pkg::S_STAT][c16_pkg::B_FAULT] = 1'b1;
               end else begin
                  s_n[c16_pkg::S_HI] = md_res.hi;
                  s_n[c16_pkg::S_LOW] = md_res.lo;
                  g_n[mid] = md_res.hi;
               end
            end
            4'd6: g_n[mid] = {lo8, ra1[7:0]};
            4'd7: g_n[mid] = {ra1[15:8], lo8};
            4'd8: g_n[mid] = {{8{lo8[7]}}, lo8};
            4'd9: g_n[mid] = {8'd0, lo8};
            4'd10: if (stat[c16_pkg::B_CMP]) nxt = 16'(pc + c12) & 16'hFFFE;
            4'd11: g_n[mid] = rb1 & rc1;
            4'd12: g_n[mid] = rb1 | rc1;
            4'd13: g_n[mid] = rb1 ^ rc1;
            4'd14: begin
               sum = {ra1[15], ra1} + {{9{lo8[7]}}, lo8};
               s_n[c16_pkg::S_STAT][c16_pkg::B_CARRY] = sum[16];
               g_n[mid] = sum[15:0];
            end
            default: if (stat[c16_pkg::B_CMP]) nxt = {ins_ff[11:0], 4'd0};
         endcase
         s_n[c16_pkg::S_PC] = nxt;
         s_n[c16_pkg::S_CLK] = 16'(spr_ff[c16_pkg::S_CLK] + 16'd1);
      end else if (cur_ff.op == c16_pkg::OP_IN) begin
         if (!stat[c16_pkg::B_INW]) begin
            s_n[c16_pkg::S_STAT][c16_pkg::B_INW] = 1'b1;
            s_n[c16_pkg::S_IN] = cur_ff.in_word;
            rsp_in.accepted = 1'b1;
         end
      end else if (cur_ff.op == c16_pkg::OP_OUT) begin
         if (stat[c16_pkg::B_OUTW]) begin
            s_n[c16_pkg::S_STAT][c16_pkg::B_OUTW] = 1'b0;
            rsp_in.accepted = 1'b1;
            rsp_in.out_word = spr_ff[c16_pkg::S_OUT];
            rsp_in.out_kind = stat[c16_pkg::B_OTYPE];
         end
      end
      rsp_in.halted = s_n[c16_pkg::S_STAT][c16_pkg::B_KILL];
      rsp_in.debug_hit = s_n[c16_pkg::S_STAT][c16_pkg::B_DEBUG];
      rsp_in.arith_fault = s_n[c16_pkg::S_STAT][c16_pkg::B_FAULT];
      rsp_in.pc_now = s_n[c16_pkg::S_PC];
      // Debug is reported once and then cleared.
      s_n[c16_pkg::S_STAT][c16_pkg::B_DEBUG] = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= c16_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 16; i++) gpr_ff[i] <= 16'd0;
         for (int i = 0; i < 8; i++) spr_ff[i] <= 16'd0;
      end else begin
         state_ff <= state_in;
         if (state_ff == c16_pkg::ST_FINISH) begin
            rsp_valid_ff <= 1'b1;
            for (int i = 0; i < 16; i++) gpr_ff[i] <= g_n[i];
            for (int i = 0; i < 8; i++) spr_ff[i] <= s_n[i];
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (state_ff == c16_pkg::ST_IDLE && req.valid && req.ready) begin
         cur_ff <= req.data;
      end
      if (state_ff == c16_pkg::ST_FINISH) begin
         rsp_ff <= rsp_in;
      end
      ins_ff <= ins_in;
      lob_ff <= lob_in;
   end

   assign req.ready = (state_ff == c16_pkg::ST_IDLE) && !rsp_valid_ff;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.data = rsp_ff;
endmodule
